// ===== hw/rtl/pcm_fms_pkg.sv =====
// Package for the PCM frame master: shared constants and the item and result types.
// It has no dependencies. The interfaces and all modules of the block use it.
package pcm_fms_pkg;

  // Default frame shape: word width and number of slots per frame.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SLOTS_DEF       = 2;

  // The sync pulse lasts two ticks, clock high and then clock low.
  localparam int SYNC_TICKS = 2;

  // Width of the transmit and receive words on the pins of the block.
  localparam int WORD_W = 16;

  // One input item, which is one half-bit tick.
  typedef struct packed {
    logic              din_level;
    logic [WORD_W-1:0] tx_word;
    logic              tx_enable;
    logic              rx_enable;
  } in_item_t;

  // One result item, which holds the pin levels for the tick.
  typedef struct packed {
    logic              clk_level;
    logic              sync_level;
    logic              dout_level;
    logic [WORD_W-1:0] rx_word;
    logic              frame_done;
  } result_t;

endpackage

// ===== hw/rtl/pcm_fms_in_if.sv =====
// Input channel of the PCM frame master: valid, ready and the tick fields.
// It depends on pcm_fms_pkg for the word width.
interface pcm_fms_in_if;
  logic                          valid;
  logic                          ready;
  logic                          din_level;
  logic [pcm_fms_pkg::WORD_W-1:0] tx_word;
  logic                          tx_enable;
  logic                          rx_enable;

  modport source (output valid, output din_level, output tx_word, output tx_enable,
                  output rx_enable, input ready);
  modport sink   (input valid, input din_level, input tx_word, input tx_enable,
                  input rx_enable, output ready);
endinterface

// ===== hw/rtl/pcm_fms_out_if.sv =====
// Result channel of the PCM frame master: valid, ready and the pin levels.
// It depends on pcm_fms_pkg for the word width.
interface pcm_fms_out_if;
  logic                          valid;
  logic                          ready;
  logic                          clk_level;
  logic                          sync_level;
  logic                          dout_level;
  logic [pcm_fms_pkg::WORD_W-1:0] rx_word;
  logic                          frame_done;

  modport source (output valid, output clk_level, output sync_level, output dout_level,
                  output rx_word, output frame_done, input ready);
  modport sink   (input valid, input clk_level, input sync_level, input dout_level,
                  input rx_word, input frame_done, output ready);
endinterface

// ===== hw/rtl/pcm_fms_engine.sv =====
// Frame engine of the PCM frame master: tick phase, shift registers and pin levels.
// It depends on pcm_fms_pkg for the item and result types.
module pcm_fms_engine #(
  parameter int SAMPLE_BITS     = pcm_fms_pkg::SAMPLE_BITS_DEF,
  parameter int SLOTS_PER_FRAME = pcm_fms_pkg::SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  pcm_fms_pkg::in_item_t item,
  output pcm_fms_pkg::result_t  res
);
  import pcm_fms_pkg::*;

  localparam int FRAME_TICKS = SYNC_TICKS + 2 * SAMPLE_BITS * SLOTS_PER_FRAME;
  localparam int SLOT0_END   = SYNC_TICKS + 2 * SAMPLE_BITS;
  localparam int PW          = $clog2(FRAME_TICKS + 1);

  logic [PW-1:0]          phase_r, phase_nxt;
  logic [SAMPLE_BITS-1:0] tx_shift_r, tx_shift_nxt;
  logic [SAMPLE_BITS-1:0] rx_shift_r, rx_shift_nxt;
  logic                   dout_hold_r, dout_hold_nxt;
  logic                   tx_on_r, tx_on_nxt;
  logic                   rx_on_r, rx_on_nxt;
  logic                   active_r, active_nxt;

  logic                          start;
  logic                          last;
  logic [PW-1:0]                 p;
  logic [SAMPLE_BITS+WORD_W-1:0] tx_wide;
  logic [SAMPLE_BITS+WORD_W-1:0] rx_wide;

  // A frame starts on an idle tick with either enable set.
  assign start   = !active_r && (item.tx_enable || item.rx_enable);
  assign p       = start ? '0 : phase_r;
  assign last    = (p == PW'(FRAME_TICKS - 1));
  assign tx_wide = {{SAMPLE_BITS{1'b0}}, item.tx_word};
  assign rx_wide = {{WORD_W{1'b0}}, rx_shift_nxt};

  // Next state and pin levels for this tick.
  always_comb begin
    phase_nxt     = phase_r;
    tx_shift_nxt  = start ? tx_wide[SAMPLE_BITS-1:0] : tx_shift_r;
    rx_shift_nxt  = start ? '0 : rx_shift_r;
    tx_on_nxt     = start ? item.tx_enable : tx_on_r;
    rx_on_nxt     = start ? item.rx_enable : rx_on_r;
    dout_hold_nxt = dout_hold_r;
    active_nxt    = active_r || start;
    res           = '0;
    if (active_nxt) begin
      if (p < PW'(SYNC_TICKS)) begin
        res.sync_level = 1'b1;
        res.clk_level  = (p == '0);
      end else if (!p[0]) begin
        // Rising clock tick: drive the next bit, MSB first, zero fill behind it.
        res.clk_level = 1'b1;
        if (tx_on_nxt) begin
          dout_hold_nxt = tx_shift_nxt[SAMPLE_BITS-1];
          tx_shift_nxt  = {tx_shift_nxt[SAMPLE_BITS-2:0], 1'b0};
        end
      end else if (rx_on_nxt && (p < PW'(SLOT0_END))) begin
        // Falling clock tick of the first slot: sample data-in.
        rx_shift_nxt = {rx_shift_nxt[SAMPLE_BITS-2:0], item.din_level};
      end
      if (last) begin
        res.frame_done = 1'b1;
        res.rx_word    = rx_wide[WORD_W-1:0];
        active_nxt     = 1'b0;
        phase_nxt      = '0;
      end else begin
        phase_nxt = p + 1'b1;
      end
    end
    res.dout_level = dout_hold_nxt;
  end

  // Frame state, advanced once per tick that reaches this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      tx_shift_r  <= '0;
      rx_shift_r  <= '0;
      dout_hold_r <= 1'b0;
      tx_on_r     <= 1'b0;
      rx_on_r     <= 1'b0;
      active_r    <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tx_shift_r  <= tx_shift_nxt;
      rx_shift_r  <= rx_shift_nxt;
      dout_hold_r <= dout_hold_nxt;
      tx_on_r     <= tx_on_nxt;
      rx_on_r     <= rx_on_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule

// ===== hw/rtl/pcm_frame_master_serdes.sv =====
// PCM frame master: input register, frame engine and result register.
// A tick sits in the input register, then its result in the result register until taken.
// Throughput is one tick per cycle unless out_ch stalls, held by the two registers.
// Synchronous active-low reset empties both registers and puts the frame idle.
// It depends on pcm_fms_pkg, the two channel interfaces and pcm_fms_engine.
module pcm_frame_master_serdes #(
  parameter int SAMPLE_BITS     = pcm_fms_pkg::SAMPLE_BITS_DEF,
  parameter int SLOTS_PER_FRAME = pcm_fms_pkg::SLOTS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  pcm_fms_in_if.sink    in_ch,
  pcm_fms_out_if.source out_ch
);
  import pcm_fms_pkg::*;

  logic     s1_v_r, s1_v_nxt;
  in_item_t s1_r;
  logic     out_v_r, out_v_nxt;
  result_t  out_r;
  result_t  res;
  logic     out_free;
  logic     in_xfer;
  logic     step;

  // The input register advances whenever the result register can take a tick.
  assign out_free    = !out_v_r || out_ch.ready;
  assign step        = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign s1_v_nxt    = in_xfer || (s1_v_r && !step);
  assign out_v_nxt   = step || (out_v_r && !out_ch.ready);

  pcm_fms_engine #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_r),
    .res   (res)
  );

  // Valid flags of the two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload of the input register and the result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.din_level <= in_ch.din_level;
      s1_r.tx_word   <= in_ch.tx_word;
      s1_r.tx_enable <= in_ch.tx_enable;
      s1_r.rx_enable <= in_ch.rx_enable;
    end
    if (step) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.clk_level  = out_r.clk_level;
  assign out_ch.sync_level = out_r.sync_level;
  assign out_ch.dout_level = out_r.dout_level;
  assign out_ch.rx_word    = out_r.rx_word;
  assign out_ch.frame_done = out_r.frame_done;

endmodule

// ===== hw/rtl/pcm_fms_checker.sv =====
// Port checker for the PCM frame master, with its bind to the top level.
// It depends on pcm_fms_pkg for the word width.
module pcm_fms_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           clk_level,
  input logic                           sync_level,
  input logic                           dout_level,
  input logic [pcm_fms_pkg::WORD_W-1:0] rx_word,
  input logic                           frame_done
);
  import pcm_fms_pkg::*;

  // A received word only shows on the last tick of a frame.
  a_rx_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (rx_word != '0)) |-> frame_done)
    else $error("rx_word nonzero outside frame end");

  // The last tick of a frame is a falling data tick, never a sync tick.
  a_end_is_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && frame_done) |-> (!clk_level && !sync_level))
    else $error("frame end with clock or sync high");

  // A sync tick carries no frame end.
  a_sync_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && sync_level) |-> (!frame_done && (rx_word == '0)))
    else $error("sync tick reports a frame end");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(clk_level) && $stable(sync_level)
      && $stable(dout_level) && $stable(rx_word) && $stable(frame_done)))
    else $error("stalled result changed");

endmodule

bind pcm_frame_master_serdes pcm_fms_checker u_pcm_fms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .clk_level  (out_ch.clk_level),
  .sync_level (out_ch.sync_level),
  .dout_level (out_ch.dout_level),
  .rx_word    (out_ch.rx_word),
  .frame_done (out_ch.frame_done)
);
